@@ rtl/prx_pkg.sv @@
package prx_pkg;

  localparam int MAX_RUN_DEF  = 256;
  localparam int MAX_HOLD_DEF = 32;

  // Hold counts and the threshold fit in six bits while MAX_HOLD is at most 63.
  localparam int CNT_W     = 6;
  localparam int MIN_LEN_W = 6;

  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd4;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_end;
    logic       last_result;
  } out_item_t;

  // Work handed from the run tracker to the drain side for one accepted byte.
  typedef struct packed {
    logic             direct;
    logic [7:0]       dbyte;
    logic [CNT_W-1:0] rel_n;
    logic             nl;
  } job_t;

  function automatic logic is_text_char(input logic [7:0] b);
    return ((b >= CHAR_SPACE) && (b <= CHAR_TILDE)) || (b == CHAR_TAB);
  endfunction

endpackage

@@ rtl/printable_run_extractor.sv @@
// Channel   Direction  Handshake           Beat
// in_       input      in_valid/in_stall   in_item (byte, end of file)
// out_      output     out_valid/out_stall out_item (byte, string end, last)
// cfg_      input      cfg_valid/cfg_ready cfg_data (min_length)
//
// A byte is taken while in_stall is low; one that yields results holds in_stall
// until its last result is in the output register. Held bytes are read through the
// registered hold memory; MAX_HOLD held bytes and a closing newline stall it longest.
// The last result of a byte sits in the output register while the next byte is taken.
// Reset is synchronous and active low; the hold memory needs no clearing pass.
// out_stall freezes the output register, the read sequence and result emission.
module printable_run_extractor #(
  parameter int MAX_RUN  = prx_pkg::MAX_RUN_DEF,
  parameter int MAX_HOLD = prx_pkg::MAX_HOLD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  prx_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output prx_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prx_pkg::MIN_LEN_W-1:0] cfg_data
);
  import prx_pkg::*;

  localparam int AW = $clog2(MAX_HOLD);

  logic [MIN_LEN_W-1:0] min_len_r, min_len_nxt;
  logic [CNT_W-1:0]     thr;
  logic                 accept;
  logic                 busy;
  job_t                 job;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    min_len_nxt = (cfg_valid && cfg_ready) ? cfg_data : min_len_r;
    // The threshold is clamped to 1..MAX_HOLD.
    if (min_len_r == '0) begin
      thr = CNT_W'(1);
    end else if ((CNT_W + 1)'(min_len_r) > (CNT_W + 1)'(MAX_HOLD)) begin
      thr = CNT_W'(MAX_HOLD);
    end else begin
      thr = CNT_W'(min_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else begin
      min_len_r <= min_len_nxt;
    end
  end

  prx_run_ctrl #(
    .MAX_RUN  (MAX_RUN),
    .MAX_HOLD (MAX_HOLD)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .thr     (thr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .job     (job)
  );

  prx_hold_mem #(
    .DEPTH (MAX_HOLD)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prx_drain #(
    .MAX_HOLD (MAX_HOLD)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .job       (job),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_job_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (job.direct || (job.rel_n != '0) || job.nl)) |=> in_stall)
    else $error("byte with pending results did not stall the input");

  a_direct_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && job.direct) |-> (job.rel_n == '0))
    else $error("pass-through byte and held-byte release in one job");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (accept && !rd_en))
    else $error("hold memory written outside an accepted beat");

  a_read_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> in_stall)
    else $error("hold memory read while the input is open");

endmodule

@@ rtl/prx_hold_mem.sv @@
module prx_hold_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled beat keeps its byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/prx_run_ctrl.sv @@
module prx_run_ctrl #(
  parameter int MAX_RUN  = 256,
  parameter int MAX_HOLD = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  prx_pkg::in_item_t           item,
  input  logic [prx_pkg::CNT_W-1:0]   thr,
  output logic                        wr_en,
  output logic [$clog2(MAX_HOLD)-1:0] wr_addr,
  output logic [7:0]                  wr_data,
  output prx_pkg::job_t               job
);
  import prx_pkg::*;

  localparam int RC_W = $clog2(MAX_RUN + 1);
  localparam int AW   = $clog2(MAX_HOLD);
  localparam int CW   = (RC_W > CNT_W) ? RC_W : CNT_W;

  logic [RC_W-1:0] rc_r, rc_nxt;
  logic            rep_r, rep_nxt;

  logic            prn;
  logic            below_run;
  logic [RC_W-1:0] rc_new;
  logic            due;
  logic            close;
  logic            rep_after;

  always_comb begin
    prn       = is_text_char(item.in_byte);
    below_run = rc_r < RC_W'(MAX_RUN);
    rc_new    = (prn && below_run) ? rc_r + RC_W'(1) : rc_r;
    due       = !rep_r && (CW'(rc_new) >= CW'(thr));
    rep_after = rep_r || due;
    close     = !prn || item.end_of_file;

    job.direct = prn && below_run && rep_r;
    job.dbyte  = item.in_byte;
    if (!due) begin
      job.rel_n = '0;
    end else if (CW'(rc_new) > CW'(MAX_HOLD)) begin
      job.rel_n = CNT_W'(MAX_HOLD);
    end else begin
      job.rel_n = CNT_W'(rc_new);
    end
    job.nl = close && rep_after;

    wr_en   = accept && prn && below_run && !rep_r && (CW'(rc_r) < CW'(MAX_HOLD));
    wr_addr = rc_r[AW-1:0];
    wr_data = item.in_byte;

    rc_nxt  = rc_r;
    rep_nxt = rep_r;
    if (accept) begin
      rc_nxt  = close ? '0 : rc_new;
      rep_nxt = close ? 1'b0 : rep_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r  <= '0;
      rep_r <= 1'b0;
    end else begin
      rc_r  <= rc_nxt;
      rep_r <= rep_nxt;
    end
  end

endmodule

@@ rtl/prx_drain.sv @@
module prx_drain #(
  parameter int MAX_HOLD = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  prx_pkg::job_t               job,
  output logic                        rd_en,
  output logic [$clog2(MAX_HOLD)-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output prx_pkg::out_item_t          out_item
);
  import prx_pkg::*;

  localparam int AW = $clog2(MAX_HOLD);

  logic             dir_r, dir_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             rdv_r, rdv_nxt;
  logic             nl_r, nl_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        oi_r, oi_nxt;

  logic load_ok;
  logic take_rd;
  logic issue;
  logic emit_dir;
  logic emit_nl;

  always_comb begin
    load_ok  = !ov_r || !out_stall;
    take_rd  = rdv_r && load_ok;
    // A new read goes out only when the read register is empty or its byte is taken into the output register.
    issue    = (left_r != '0) && (!rdv_r || take_rd);
    emit_dir = dir_r && load_ok;
    emit_nl  = nl_r && !dir_r && (left_r == '0) && !rdv_r && load_ok;

    rd_en   = issue;
    rd_addr = idx_r;
    busy    = dir_r || rdv_r || (left_r != '0) || nl_r;

    oi_nxt = oi_r;
    ov_nxt = load_ok ? 1'b0 : ov_r;
    if (emit_dir) begin
      oi_nxt = '{out_byte: byte_r, string_end: 1'b0, last_result: !nl_r};
      ov_nxt = 1'b1;
    end else if (take_rd) begin
      oi_nxt = '{out_byte: rd_data, string_end: 1'b0,
                 last_result: (left_r == '0) && !nl_r};
      ov_nxt = 1'b1;
    end else if (emit_nl) begin
      oi_nxt = '{out_byte: CHAR_NL, string_end: 1'b1, last_result: 1'b1};
      ov_nxt = 1'b1;
    end

    dir_nxt  = emit_dir ? 1'b0 : dir_r;
    byte_nxt = byte_r;
    left_nxt = issue ? left_r - CNT_W'(1) : left_r;
    idx_nxt  = issue ? idx_r + AW'(1) : idx_r;
    rdv_nxt  = issue ? 1'b1 : (take_rd ? 1'b0 : rdv_r);
    nl_nxt   = emit_nl ? 1'b0 : nl_r;
    if (load) begin
      dir_nxt  = job.direct;
      byte_nxt = job.dbyte;
      left_nxt = job.rel_n;
      idx_nxt  = '0;
      nl_nxt   = job.nl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      left_r <= '0;
      rdv_r  <= 1'b0;
      nl_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      dir_r  <= dir_nxt;
      left_r <= left_nxt;
      rdv_r  <= rdv_nxt;
      nl_r   <= nl_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    idx_r  <= idx_nxt;
    oi_r   <= oi_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule

@@ tb/sv/tb_printable_run_extractor.sv @@
module tb_printable_run_extractor;
  import prx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = MAX_HOLD_DEF + 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MIN_LEN_W-1:0] cfg_data = '0;

  // Predictor state: the first bytes of the current run, its length and whether it is out.
  logic [7:0] held_text [0:MAX_HOLD_DEF-1];
  logic [8:0] run_len = '0;
  logic run_shown = 1'b0;
  logic [MIN_LEN_W-1:0] min_len_q = MIN_LEN_RESET;
  out_item_t step_chars[$];
  out_item_t expected_chars[$];

  int errors = 0;
  int cycles = 0;
  bit stall_on = 1'b0;
  bit gaps_on = 1'b0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int burst_left = 0;
  out_item_t want;

  printable_run_extractor uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function bit is_text(input logic [7:0] b);
    return (b >= 8'h20 && b <= 8'h7E) || b == 8'h09;
  endfunction

  function void push_char(input logic [7:0] b, input logic nl);
    out_item_t r;
    r.out_byte = b;
    r.string_end = nl;
    r.last_result = 1'b0;
    step_chars.push_back(r);
  endfunction

  function void release_held();
    int unsigned thr;
    int unsigned n;
    thr = min_len_q;
    if (thr < 1) thr = 1;
    if (thr > MAX_HOLD_DEF) thr = MAX_HOLD_DEF;
    if (run_shown || run_len < thr) return;
    n = (run_len > MAX_HOLD_DEF) ? MAX_HOLD_DEF : run_len;
    for (int i = 0; i < n; i++) push_char(held_text[i], 1'b0);
    run_shown = 1'b1;
  endfunction

  function void close_run();
    release_held();
    if (run_shown) push_char(CHAR_NL, 1'b1);
    run_len = '0;
    run_shown = 1'b0;
  endfunction

  function void predict_byte(input in_item_t it);
    out_item_t r;
    step_chars.delete();
    if (is_text(it.in_byte)) begin
      // Past the run cap the byte is dropped but the run stays open.
      if (run_len < MAX_RUN_DEF) begin
        if (run_shown) begin
          push_char(it.in_byte, 1'b0);
        end else if (run_len < MAX_HOLD_DEF) begin
          held_text[run_len] = it.in_byte;
        end
        run_len = run_len + 1'b1;
      end
      release_held();
      if (it.end_of_file) close_run();
    end else begin
      close_run();
    end
    if (step_chars.size() > 0) begin
      r = step_chars.pop_back();
      r.last_result = 1'b1;
      step_chars.push_back(r);
    end
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endfunction

  task report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0d] %s: got %0d, expected %0d", cycles, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_item.out_byte, 0);
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_item.out_byte, want.out_byte);
        if (out_item.string_end !== want.string_end)
          report_mismatch("string_end", out_item.string_end, want.string_end);
        if (out_item.last_result !== want.last_result)
          report_mismatch("last_result", out_item.last_result, want.last_result);
      end
    end
  end

  // Receiver side: a long hold-off on request, otherwise random stall bursts while stall_on is set.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    in_item_t it;
    int gap;
    it.in_byte = b;
    it.end_of_file = eof;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(it);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Bytes that yield nothing may still be in flight, so give the block time to settle.
  task wait_quiet();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_min_len(input logic [MIN_LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_len_q = v;
  endtask

  function automatic logic [7:0] rand_printable();
    int unsigned v;
    v = $urandom_range(0, 95);
    return (v == 95) ? CHAR_TAB : 8'(32 + v);
  endfunction

  function automatic logic [7:0] rand_control();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_text(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task test_reset_threshold();
    stall_on = 1'b1;
    gaps_on = 1'b1;
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_TILDE, 1'b0);
    send_byte(CHAR_TAB, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'h61, 1'b1);
    send_byte(CHAR_NL, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_quiet();
  endtask

  task test_threshold_extremes();
    // Zero behaves as one: every printable byte is reported at once.
    write_min_len(6'd0);
    send_byte(8'h51, 1'b1);
    send_byte(8'h52, 1'b0);
    send_byte(8'h0D, 1'b0);
    wait_quiet();
    // Above the hold depth behaves as the full depth; the widest release burst.
    write_min_len(6'd63);
    for (int i = 0; i < MAX_HOLD_DEF; i++) send_byte(rand_printable(), i == MAX_HOLD_DEF - 1);
    wait_quiet();
  endtask

  task test_threshold_moves();
    write_min_len(6'd32);
    for (int i = 0; i < 10; i++) send_byte(rand_printable(), 1'b0);
    wait_quiet();
    // Lowered below the held count: a control byte releases the run and closes it.
    write_min_len(6'd3);
    send_byte(8'h01, 1'b0);
    wait_quiet();
    write_min_len(6'd20);
    for (int i = 0; i < 5; i++) send_byte(rand_printable(), 1'b0);
    wait_quiet();
    write_min_len(6'd2);
    send_byte(8'h7A, 1'b0);
    wait_quiet();
    // Raised after release: the run keeps streaming.
    write_min_len(6'd50);
    send_byte(8'h6B, 1'b0);
    send_byte(8'h7F, 1'b0);
    wait_quiet();
  endtask

  task test_overlong_run_backpressure();
    stall_on = 1'b0;
    gaps_on = 1'b0;
    write_min_len(6'd1);
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < MAX_RUN_DEF + 2; i++) send_byte(rand_printable(), 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_quiet();
  endtask

  task automatic test_random_text(input int n_items, input logic [MIN_LEN_W-1:0] ml);
    int sent;
    int shape;
    int len;
    int thr;
    int k;
    bit eof_last;
    stall_on = $urandom_range(0, 3) != 0;
    gaps_on = $urandom_range(0, 3) != 0;
    write_min_len(ml);
    thr = (ml < 1) ? 1 : ((ml > MAX_HOLD_DEF) ? MAX_HOLD_DEF : ml);
    sent = 0;
    while (sent < n_items) begin
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          sent++;
        end
      end else begin
        if (shape < 10) len = $urandom_range(1, 8);
        else if (shape < 17) len = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 3);
        else len = $urandom_range(30, 45);
        eof_last = $urandom_range(0, 4) == 0;
        for (int i = 0; i < len; i++) begin
          send_byte(rand_printable(), eof_last && i == len - 1);
          sent++;
        end
        if (!eof_last) begin
          send_byte(rand_control(), $urandom_range(0, 9) == 0);
          sent++;
        end
      end
      if ($urandom_range(0, 11) == 0) drain_results();
    end
    wait_quiet();
  endtask

  task test_quiet_tail();
    stall_on = 1'b0;
    gaps_on = 1'b0;
    write_min_len(6'd4);
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 5) == 0) send_byte(rand_control(), 1'b0);
      else send_byte(rand_printable(), i == 11);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_threshold();
    test_threshold_extremes();
    test_threshold_moves();
    test_overlong_run_backpressure();
    test_random_text(12, 6'd1);
    test_random_text(12, 6'($urandom_range(0, 63)));
    test_quiet_tail();
    wait_quiet();
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
